// ===== hw/rtl/bgl_pkg.sv =====
// shared types and constants for the bitmap glyph layout engine
`default_nettype none

package bgl_pkg;

  // item kinds carried on the request sideband
  localparam logic [1:0] ACT_LOAD  = 2'd0;
  localparam logic [1:0] ACT_BEGIN = 2'd1;
  localparam logic [1:0] ACT_CHAR  = 2'd2;

  // character codes with special handling
  localparam logic [7:0] CODE_NEWLINE = 8'd10;
  localparam logic [7:0] CODE_SPACE   = 8'd32;

  // configuration register indexes
  localparam int unsigned CFG_ADDR_W = 3;
  localparam int unsigned CFG_DATA_W = 24;
  localparam logic [CFG_ADDR_W-1:0] REG_LINE_HEIGHT = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_PAD_TOP     = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_PAD_RIGHT   = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_PAD_BOTTOM  = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_PAD_LEFT    = 3'd4;
  localparam logic [CFG_ADDR_W-1:0] REG_TINT_RGB    = 3'd5;

  localparam int unsigned IN_DATA_W  = 120;
  localparam int unsigned OUT_DATA_W = 104;

  // one glyph table entry
  typedef struct packed {
    logic [11:0]        src_x;
    logic [11:0]        src_y;
    logic [9:0]         width;
    logic [9:0]         height;
    logic signed [9:0]  x_off;
    logic signed [9:0]  y_off;
    logic [9:0]         advance;
  } glyph_t;

  // layout settings
  typedef struct packed {
    logic [9:0]  line_height;
    logic [7:0]  pad_top;
    logic [7:0]  pad_right;
    logic [7:0]  pad_bottom;
    logic [7:0]  pad_left;
    logic [23:0] tint_rgb;
  } cfg_t;

  // request fields needed after the table read
  typedef struct packed {
    logic [1:0]         action;
    logic [7:0]         char_code;
    logic signed [15:0] origin_x;
    logic signed [15:0] origin_y;
  } item_t;

  // blit command, last member in the lowest bits
  typedef struct packed {
    logic [23:0] tint;
    logic [15:0] dest_y;
    logic [15:0] dest_x;
    logic [9:0]  src_height;
    logic [9:0]  src_width;
    logic [11:0] src_y;
    logic [11:0] src_x;
  } blit_t;

endpackage

`default_nettype wire

// ===== hw/rtl/bgl_glyph_mem.sv =====
// glyph table memory with per-entry valid bits and registered read
`default_nettype none

module bgl_glyph_mem
  import bgl_pkg::*;
#(
  parameter int unsigned GLYPH_COUNT = 256
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       rd_en,
  input  wire logic [7:0] rd_code,
  input  wire logic       wr_en,
  input  wire logic [7:0] wr_code,
  input  wire glyph_t     wr_glyph,
  output glyph_t          rd_glyph,
  output logic            rd_hit
);

  localparam int unsigned IDX_W = $clog2(GLYPH_COUNT);
  localparam logic [8:0]  COUNT_9 = 9'(GLYPH_COUNT);

  glyph_t             mem [GLYPH_COUNT];
  logic [GLYPH_COUNT-1:0] valid_r;
  glyph_t             rd_glyph_r;
  logic               rd_hit_r;
  logic               rd_in_range;
  logic               wr_in_range;

  assign rd_in_range = {1'b0, rd_code} < COUNT_9;
  assign wr_in_range = {1'b0, wr_code} < COUNT_9;

  always_ff @(posedge clk) begin
    if (wr_en && wr_in_range) begin
      mem[wr_code[IDX_W-1:0]] <= wr_glyph;
    end
    if (rd_en) begin
      rd_glyph_r <= mem[rd_code[IDX_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r  <= '0;
      rd_hit_r <= 1'b0;
    end else begin
      if (wr_en && wr_in_range) begin
        valid_r[wr_code[IDX_W-1:0]] <= 1'b1;
      end
      if (rd_en) begin
        rd_hit_r <= rd_in_range && valid_r[rd_code[IDX_W-1:0]];
      end
    end
  end

  assign rd_glyph = rd_glyph_r;
  assign rd_hit   = rd_hit_r;

endmodule

`default_nettype wire

// ===== hw/rtl/bgl_pen.sv =====
// pen stage: pen registers, destination arithmetic and blit build
`default_nettype none

module bgl_pen
  import bgl_pkg::*;
#(
  parameter int unsigned COORD_BITS = 16
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  load,
  input  wire item_t item,
  input  wire cfg_t  cfg,
  input  wire glyph_t glyph,
  input  wire logic  hit,
  input  wire logic  adv,
  output logic       busy,
  output logic       emit,
  output blit_t      blit
);

  localparam int unsigned EW = ((COORD_BITS > 16) ? COORD_BITS : 16) + 2;
  localparam logic signed [EW-1:0] SAT_HI = EW'((2 ** (COORD_BITS - 1)) - 1);
  localparam logic signed [EW-1:0] SAT_LO = ~SAT_HI;

  function automatic logic signed [COORD_BITS-1:0] sat_c(input logic signed [EW-1:0] v);
    logic signed [EW-1:0] r;
    begin
      if (v > SAT_HI) begin
        r = SAT_HI;
      end else if (v < SAT_LO) begin
        r = SAT_LO;
      end else begin
        r = v;
      end
      sat_c = r[COORD_BITS-1:0];
    end
  endfunction

  logic                         s1_valid_r;
  item_t                        s1_item_r;
  logic signed [COORD_BITS-1:0] pen_x_r, pen_x_nxt;
  logic signed [COORD_BITS-1:0] pen_y_r, pen_y_nxt;
  logic signed [COORD_BITS-1:0] line_x_r, line_x_nxt;

  logic signed [COORD_BITS-1:0] dx_sat, dy_sat, adv_x_sat, nl_y_sat;
  logic signed [COORD_BITS-1:0] org_x_sat, org_y_sat;
  logic signed [EW-1:0]         dx_sum, dy_sum, adv_sum, nl_sum;
  logic signed [EW-1:0]         dx_e, dy_e;
  logic                         is_char;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (load) begin
      s1_valid_r <= 1'b1;
    end else if (adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      s1_item_r <= item;
    end
  end

  // destination and pen arithmetic, all in a widened signed domain
  always_comb begin
    dx_sum = EW'(pen_x_r) + $signed(EW'(cfg.pad_left));
    dx_sat = sat_c(dx_sum);
    dy_sum = EW'(pen_y_r) + EW'(glyph.y_off) + $signed(EW'(cfg.pad_top));
    dy_sat = sat_c(dy_sum);
    adv_sum = EW'(dx_sat) + $signed(EW'(glyph.advance)) + $signed(EW'(cfg.pad_right))
              - EW'(glyph.x_off);
    adv_x_sat = sat_c(adv_sum);
    nl_sum = EW'(pen_y_r) + $signed(EW'(cfg.line_height)) + $signed(EW'(cfg.pad_bottom));
    nl_y_sat = sat_c(nl_sum);
    org_x_sat = sat_c(EW'(s1_item_r.origin_x));
    org_y_sat = sat_c(EW'(s1_item_r.origin_y));
    dx_e = EW'(dx_sat);
    dy_e = EW'(dy_sat);
  end

  assign is_char = s1_valid_r && (s1_item_r.action == ACT_CHAR);

  always_comb begin
    pen_x_nxt  = pen_x_r;
    pen_y_nxt  = pen_y_r;
    line_x_nxt = line_x_r;
    if (s1_valid_r && adv) begin
      if (s1_item_r.action == ACT_BEGIN) begin
        pen_x_nxt  = org_x_sat;
        pen_y_nxt  = org_y_sat;
        line_x_nxt = org_x_sat;
      end else if (s1_item_r.action == ACT_CHAR) begin
        if (hit) begin
          pen_x_nxt = adv_x_sat;
        end else if (s1_item_r.char_code == CODE_NEWLINE) begin
          pen_x_nxt = line_x_r;
          pen_y_nxt = nl_y_sat;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pen_x_r  <= '0;
      pen_y_r  <= '0;
      line_x_r <= '0;
    end else begin
      pen_x_r  <= pen_x_nxt;
      pen_y_r  <= pen_y_nxt;
      line_x_r <= line_x_nxt;
    end
  end

  assign busy = s1_valid_r;
  assign emit = is_char && hit && (s1_item_r.char_code != CODE_SPACE);

  always_comb begin
    blit.src_x      = glyph.src_x;
    blit.src_y      = glyph.src_y;
    blit.src_width  = glyph.width;
    blit.src_height = glyph.height;
    blit.dest_x     = dx_e[15:0];
    blit.dest_y     = dy_e[15:0];
    blit.tint       = cfg.tint_rgb;
  end

endmodule

`default_nettype wire

// ===== hw/rtl/bitmap_glyph_layout.sv =====
// top level of the bitmap glyph layout engine
`default_nettype none

// Text layout for one bitmap font. A load request writes one glyph table entry,
// a begin request places the pen at an origin, and a character request looks up
// its glyph and produces a blit command (none for space, a missing glyph or a
// load or begin). A missing newline glyph moves the pen down one line and back
// to the line start. Rate: one request per cycle while blit commands are taken.
// Each request is registered into the pen stage together with its glyph table
// read (one synchronous read port); the pen is updated there so the next
// character sees it at once, and a blit command then moves on to the output
// register. in_tready drops only while the pen stage holds a blit and the output
// register is full and not being taken. The valid map is cleared at reset all
// at once, so there is no clearing pass. Settings on the cfg_ port must be
// written only while no request is in flight; the block does not enforce this.

module bitmap_glyph_layout
  import bgl_pkg::*;
#(
  parameter int unsigned GLYPH_COUNT = 256,
  parameter int unsigned COORD_BITS  = 16
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  // request channel
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  // tdata, low bit up: char_code 8, glyph_src_x 12, glyph_src_y 12,
  // glyph_width 10, glyph_height 10, glyph_x_offset 10, glyph_y_offset 10,
  // glyph_advance 10, origin_x 16, origin_y 16, zero fill 6
  input  wire logic [IN_DATA_W-1:0]  in_tdata,
  // tuser: action 2
  input  wire logic [1:0]            in_tuser,
  // blit command channel
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  // tdata, low bit up: src_x 12, src_y 12, src_width 10, src_height 10,
  // dest_x 16, dest_y 16, tint 24, zero fill 4
  output logic [OUT_DATA_W-1:0]      out_tdata,
  // settings write port
  input  wire logic                  cfg_wr_en,
  input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

  cfg_t   cfg_r;
  glyph_t wr_glyph;
  glyph_t rd_glyph;
  item_t  in_item;
  blit_t  blit;
  logic   rd_hit;
  logic   in_fire;
  logic   s1_busy;
  logic   s1_emit;
  logic   s1_adv;
  logic   out_tvalid_r;
  blit_t  out_blit_r;

  // settings registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.line_height <= 10'd16;
      cfg_r.pad_top     <= 8'd0;
      cfg_r.pad_right   <= 8'd0;
      cfg_r.pad_bottom  <= 8'd0;
      cfg_r.pad_left    <= 8'd0;
      cfg_r.tint_rgb    <= 24'hFFFFFF;
    end else if (cfg_wr_en) begin
      unique case (cfg_addr)
        REG_LINE_HEIGHT: cfg_r.line_height <= cfg_wdata[9:0];
        REG_PAD_TOP:     cfg_r.pad_top     <= cfg_wdata[7:0];
        REG_PAD_RIGHT:   cfg_r.pad_right   <= cfg_wdata[7:0];
        REG_PAD_BOTTOM:  cfg_r.pad_bottom  <= cfg_wdata[7:0];
        REG_PAD_LEFT:    cfg_r.pad_left    <= cfg_wdata[7:0];
        REG_TINT_RGB:    cfg_r.tint_rgb    <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // unpack the request
  always_comb begin
    wr_glyph.src_x   = in_tdata[19:8];
    wr_glyph.src_y   = in_tdata[31:20];
    wr_glyph.width   = in_tdata[41:32];
    wr_glyph.height  = in_tdata[51:42];
    wr_glyph.x_off   = in_tdata[61:52];
    wr_glyph.y_off   = in_tdata[71:62];
    wr_glyph.advance = in_tdata[81:72];
    in_item.action    = in_tuser;
    in_item.char_code = in_tdata[7:0];
    in_item.origin_x  = in_tdata[97:82];
    in_item.origin_y  = in_tdata[113:98];
  end

  // pen stage moves on unless it holds a blit that has nowhere to go
  assign s1_adv    = !s1_emit || !out_tvalid_r || out_tready;
  assign in_tready = !s1_busy || s1_adv;
  assign in_fire   = in_tvalid && in_tready;

  bgl_glyph_mem #(
    .GLYPH_COUNT (GLYPH_COUNT)
  ) u_mem (
    .clk      (clk),
    .rst_n    (rst_n),
    .rd_en    (in_fire && (in_tuser == ACT_CHAR)),
    .rd_code  (in_tdata[7:0]),
    .wr_en    (in_fire && (in_tuser == ACT_LOAD)),
    .wr_code  (in_tdata[7:0]),
    .wr_glyph (wr_glyph),
    .rd_glyph (rd_glyph),
    .rd_hit   (rd_hit)
  );

  bgl_pen #(
    .COORD_BITS (COORD_BITS)
  ) u_pen (
    .clk   (clk),
    .rst_n (rst_n),
    .load  (in_fire),
    .item  (in_item),
    .cfg   (cfg_r),
    .glyph (rd_glyph),
    .hit   (rd_hit),
    .adv   (s1_adv),
    .busy  (s1_busy),
    .emit  (s1_emit),
    .blit  (blit)
  );

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (s1_emit && s1_adv) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_emit && s1_adv) begin
      out_blit_r <= blit;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {4'b0000, out_blit_r};

endmodule

`default_nettype wire
